FILE: src/ddc_pkg.sv
// Shared types, constants and the glyph ROM for the debounced digit counter.
package ddc_pkg;

	localparam int PIXEL_COUNT = 25;
	localparam int GLYPH_N     = 5;
	localparam int IDX_W       = 5;
	localparam int POS_W       = 3;
	localparam int DIGIT_W     = 4;
	localparam int COLOR_W     = 24;
	localparam int DBN_W       = 16;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 24;

	localparam logic [DBN_W-1:0]   DBN_RESET   = 16'd50;
	localparam logic [COLOR_W-1:0] COLOR_RESET = 24'h00FF00;
	localparam logic [DIGIT_W-1:0] DIGIT_MAX   = 4'd9;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DEBOUNCE = 1'b0,
		CFG_ON_COLOR = 1'b1
	} cfg_reg_t;

	// Input operation codes
	typedef enum logic {
		OP_TICK   = 1'b0,
		OP_REDRAW = 1'b1
	} op_t;

	// Button state
	typedef enum logic [2:0] {
		MODE_RELEASED   = 3'b001,
		MODE_PRESSED    = 3'b010,
		MODE_DEBOUNCING = 3'b100
	} mode_t;

	// Sequencer state
	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_RES_A = 5'b00010,
		ST_RES_B = 5'b00100,
		ST_FRAME = 5'b01000,
		ST_REL   = 5'b10000
	} seq_t;

	// Control into and out of the shared debounce unit
	typedef struct packed {
		mode_t mode;
		logic  started;
		logic  low;
	} dbn_req_t;

	typedef struct packed {
		mode_t mode;
		logic  fire;
	} dbn_rsp_t;

	// Glyph rows, top row first; column 0 is bit 4
	localparam logic [GLYPH_N-1:0] GLYPH_ROM [10][GLYPH_N] = '{
		'{5'd31, 5'd17, 5'd17, 5'd17, 5'd31},
		'{5'd4,  5'd12, 5'd4,  5'd4,  5'd14},
		'{5'd12, 5'd10, 5'd8,  5'd4,  5'd30},
		'{5'd31, 5'd1,  5'd31, 5'd1,  5'd31},
		'{5'd17, 5'd17, 5'd31, 5'd1,  5'd16},
		'{5'd15, 5'd16, 5'd7,  5'd2,  5'd15},
		'{5'd31, 5'd16, 5'd31, 5'd17, 5'd31},
		'{5'd31, 5'd2,  5'd4,  5'd8,  5'd1},
		'{5'd31, 5'd17, 5'd31, 5'd17, 5'd31},
		'{5'd31, 5'd17, 5'd31, 5'd1,  5'd31}
	};

	// One glyph row; digits above nine draw blank
	function automatic logic [GLYPH_N-1:0] glyph_row(input logic [DIGIT_W-1:0] digit,
			input logic [POS_W-1:0] row);
		logic [GLYPH_N-1:0] bits;
		bits = '0;
		if (digit <= DIGIT_MAX && row < POS_W'(GLYPH_N)) begin
			bits = GLYPH_ROM[digit][row];
		end
		return bits;
	endfunction

endpackage

FILE: src/ddc_in_if.sv
// Input channel: tick or redraw request with button levels.
interface ddc_in_if;
	logic valid;
	logic ready;
	logic op;
	logic btn_a_level;
	logic btn_b_level;

	modport source (output valid, output op, output btn_a_level, output btn_b_level,
		input ready);
	modport sink (input valid, input op, input btn_a_level, input btn_b_level,
		output ready);
endinterface

FILE: src/ddc_out_if.sv
// Output channel: one glyph pixel per beat.
interface ddc_out_if;
	logic                               valid;
	logic                               ready;
	logic [ddc_pkg::COLOR_W-1:0]        pixel_color;
	logic [ddc_pkg::IDX_W-1:0]          pixel_index;
	logic [ddc_pkg::DIGIT_W-1:0]        shown_digit;
	logic                               last_pixel;

	modport source (output valid, output pixel_color, output pixel_index,
		output shown_digit, output last_pixel, input ready);
	modport sink (input valid, input pixel_color, input pixel_index,
		input shown_digit, input last_pixel, output ready);
endinterface

FILE: src/ddc_cfg_if.sv
// Configuration write channel: register index and write data.
interface ddc_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [ddc_pkg::CFG_IDX_W-1:0]     index;
	logic [ddc_pkg::CFG_DATA_W-1:0]    data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

FILE: src/ddc_debounce.sv
// Shared debounce resolve unit: expiry compare and wait increment for one button.
module ddc_debounce #(
	parameter int TIMER_BITS = 16
) (
	input  ddc_pkg::dbn_req_t          req,
	input  logic [TIMER_BITS-1:0]      wait_cur,
	input  logic [ddc_pkg::DBN_W-1:0]  dbn_ticks,
	output ddc_pkg::dbn_rsp_t          rsp,
	output logic [TIMER_BITS-1:0]      wait_nxt
);

	localparam int CMP_W = (TIMER_BITS > ddc_pkg::DBN_W) ? TIMER_BITS : ddc_pkg::DBN_W;

	logic expired;

	// Expired once the count reaches the setting or saturates
	assign expired = (CMP_W'(wait_cur) >= CMP_W'(dbn_ticks)) || (&wait_cur);

	always_comb begin
		rsp.mode = req.mode;
		rsp.fire = 1'b0;
		wait_nxt = wait_cur;
		if (req.mode == ddc_pkg::MODE_DEBOUNCING && !req.started) begin
			if (expired) begin
				rsp.mode = req.low ? ddc_pkg::MODE_PRESSED : ddc_pkg::MODE_RELEASED;
				rsp.fire = req.low;
			end else begin
				wait_nxt = wait_cur + TIMER_BITS'(1);
			end
		end
	end

endmodule

FILE: src/ddc_glyph.sv
// Glyph frame streamer: walks 25 pixels, looks up the ROM, drives the output register.
module ddc_glyph (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [ddc_pkg::DIGIT_W-1:0]   digit,
	input  logic [ddc_pkg::COLOR_W-1:0]   on_color,
	output logic                          busy,
	ddc_out_if.source                     out_ch
);

	logic                          active_q;
	logic [ddc_pkg::IDX_W-1:0]     idx_q;
	logic [ddc_pkg::POS_W-1:0]     row_q;
	logic [ddc_pkg::POS_W-1:0]     col_q;
	logic                          out_valid_q;
	logic [ddc_pkg::COLOR_W-1:0]   color_q;
	logic [ddc_pkg::IDX_W-1:0]     index_q;
	logic [ddc_pkg::DIGIT_W-1:0]   digit_q;
	logic                          last_q;
	logic                          load;
	logic                          is_last;
	logic [ddc_pkg::GLYPH_N-1:0]   row_bits;
	logic                          lit;

	assign load    = active_q && (!out_valid_q || out_ch.ready);
	assign is_last = (idx_q == ddc_pkg::IDX_W'(ddc_pkg::PIXEL_COUNT - 1));
	assign busy    = active_q;

	// Rows go out bottom first
	always_comb begin
		row_bits = ddc_pkg::glyph_row(digit, ddc_pkg::POS_W'(ddc_pkg::GLYPH_N - 1) - row_q);
		lit      = row_bits[ddc_pkg::POS_W'(ddc_pkg::GLYPH_N - 1) - col_q];
	end

	// Pixel walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			idx_q    <= '0;
			row_q    <= '0;
			col_q    <= '0;
		end else if (start) begin
			active_q <= 1'b1;
			idx_q    <= '0;
			row_q    <= '0;
			col_q    <= '0;
		end else if (load) begin
			idx_q <= idx_q + ddc_pkg::IDX_W'(1);
			if (is_last) begin
				active_q <= 1'b0;
			end
			if (col_q == ddc_pkg::POS_W'(ddc_pkg::GLYPH_N - 1)) begin
				col_q <= '0;
				row_q <= row_q + ddc_pkg::POS_W'(1);
			end else begin
				col_q <= col_q + ddc_pkg::POS_W'(1);
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			color_q <= lit ? on_color : '0;
			index_q <= idx_q;
			digit_q <= digit;
			last_q  <= is_last;
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.pixel_color = color_q;
	assign out_ch.pixel_index = index_q;
	assign out_ch.shown_digit = digit_q;
	assign out_ch.last_pixel  = last_q;

endmodule

FILE: src/debounced_digit_counter_glyph_out.sv
// Debounced up/down digit counter streaming a 5x5 glyph per digit change or redraw.
// A tick steps through the accept, resolve A, resolve B and release states.
// Each frame streams 25 pixel beats; a tick emits at most two frames.
// A redraw streams one frame; the pixel sequencer and one shared debounce unit set this order.
// Reset (arst_n low): buttons released, wait counts and digit zero, registers at defaults.
module debounced_digit_counter_glyph_out #(
	parameter int TIMER_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	ddc_in_if.sink      in_ch,
	ddc_out_if.source   out_ch,
	ddc_cfg_if.sink     cfg
);

	ddc_pkg::seq_t                 state_q;
	ddc_pkg::seq_t                 ret_q;
	ddc_pkg::mode_t                mode_a_q;
	ddc_pkg::mode_t                mode_b_q;
	logic [TIMER_BITS-1:0]         wait_a_q;
	logic [TIMER_BITS-1:0]         wait_b_q;
	logic [ddc_pkg::DIGIT_W-1:0]   digit_q;
	logic                          a_low_q;
	logic                          b_low_q;
	logic                          a_start_q;
	logic                          b_start_q;
	logic [ddc_pkg::DBN_W-1:0]     dbn_ticks_q;
	logic [ddc_pkg::COLOR_W-1:0]   on_color_q;

	ddc_pkg::dbn_req_t             dbn_req;
	ddc_pkg::dbn_rsp_t             dbn_rsp;
	logic [TIMER_BITS-1:0]         wait_sel;
	logic [TIMER_BITS-1:0]         wait_nxt;
	logic                          in_beat;
	logic                          a_low;
	logic                          b_low;
	logic                          gl_start;
	logic                          gl_busy;
	logic [ddc_pkg::DIGIT_W-1:0]   digit_up;
	logic [ddc_pkg::DIGIT_W-1:0]   digit_dn;

	assign in_ch.ready = (state_q == ddc_pkg::ST_IDLE);
	assign in_beat     = in_ch.valid && in_ch.ready;
	assign a_low       = !in_ch.btn_a_level;
	assign b_low       = !in_ch.btn_b_level;
	assign cfg.ready   = 1'b1;

	assign digit_up = (digit_q >= ddc_pkg::DIGIT_MAX) ? '0 : digit_q + ddc_pkg::DIGIT_W'(1);
	assign digit_dn = (digit_q == '0) ? ddc_pkg::DIGIT_MAX : digit_q - ddc_pkg::DIGIT_W'(1);

	// Feed the shared unit with button A or B
	always_comb begin
		if (state_q == ddc_pkg::ST_RES_B) begin
			dbn_req.mode    = mode_b_q;
			dbn_req.started = b_start_q;
			dbn_req.low     = b_low_q;
			wait_sel        = wait_b_q;
		end else begin
			dbn_req.mode    = mode_a_q;
			dbn_req.started = a_start_q;
			dbn_req.low     = a_low_q;
			wait_sel        = wait_a_q;
		end
	end

	ddc_debounce #(
		.TIMER_BITS (TIMER_BITS)
	) u_debounce (
		.req       (dbn_req),
		.wait_cur  (wait_sel),
		.dbn_ticks (dbn_ticks_q),
		.rsp       (dbn_rsp),
		.wait_nxt  (wait_nxt)
	);

	// Frame kick: redraw, or a resolved press
	assign gl_start = (in_beat && in_ch.op == ddc_pkg::OP_REDRAW)
		|| ((state_q == ddc_pkg::ST_RES_A || state_q == ddc_pkg::ST_RES_B) && dbn_rsp.fire);

	ddc_glyph u_glyph (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (gl_start),
		.digit    (digit_q),
		.on_color (on_color_q),
		.busy     (gl_busy),
		.out_ch   (out_ch)
	);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dbn_ticks_q <= ddc_pkg::DBN_RESET;
			on_color_q  <= ddc_pkg::COLOR_RESET;
		end else if (cfg.valid) begin
			unique case (ddc_pkg::cfg_reg_t'(cfg.index))
				ddc_pkg::CFG_DEBOUNCE: dbn_ticks_q <= cfg.data[ddc_pkg::DBN_W-1:0];
				ddc_pkg::CFG_ON_COLOR: on_color_q  <= cfg.data[ddc_pkg::COLOR_W-1:0];
			endcase
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ddc_pkg::ST_IDLE;
			ret_q     <= ddc_pkg::ST_IDLE;
			mode_a_q  <= ddc_pkg::MODE_RELEASED;
			mode_b_q  <= ddc_pkg::MODE_RELEASED;
			wait_a_q  <= '0;
			wait_b_q  <= '0;
			digit_q   <= '0;
			a_low_q   <= 1'b0;
			b_low_q   <= 1'b0;
			a_start_q <= 1'b0;
			b_start_q <= 1'b0;
		end else begin
			unique case (state_q)
				ddc_pkg::ST_IDLE: begin
					if (in_beat) begin
						if (in_ch.op == ddc_pkg::OP_REDRAW) begin
							state_q <= ddc_pkg::ST_FRAME;
							ret_q   <= ddc_pkg::ST_IDLE;
						end else begin
							state_q   <= ddc_pkg::ST_RES_A;
							a_low_q   <= a_low;
							b_low_q   <= b_low;
							a_start_q <= 1'b0;
							b_start_q <= 1'b0;
							// Start debouncing on a fresh low level
							if (mode_a_q != ddc_pkg::MODE_PRESSED
									&& mode_a_q != ddc_pkg::MODE_DEBOUNCING && a_low) begin
								mode_a_q  <= ddc_pkg::MODE_DEBOUNCING;
								wait_a_q  <= '0;
								a_start_q <= 1'b1;
							end
							if (mode_b_q != ddc_pkg::MODE_PRESSED
									&& mode_b_q != ddc_pkg::MODE_DEBOUNCING && b_low) begin
								mode_b_q  <= ddc_pkg::MODE_DEBOUNCING;
								wait_b_q  <= '0;
								b_start_q <= 1'b1;
							end
						end
					end
				end
				ddc_pkg::ST_RES_A: begin
					mode_a_q <= dbn_rsp.mode;
					wait_a_q <= wait_nxt;
					if (dbn_rsp.fire) begin
						digit_q <= digit_up;
						state_q <= ddc_pkg::ST_FRAME;
						ret_q   <= ddc_pkg::ST_RES_B;
					end else begin
						state_q <= ddc_pkg::ST_RES_B;
					end
				end
				ddc_pkg::ST_RES_B: begin
					mode_b_q <= dbn_rsp.mode;
					wait_b_q <= wait_nxt;
					if (dbn_rsp.fire) begin
						digit_q <= digit_dn;
						state_q <= ddc_pkg::ST_FRAME;
						ret_q   <= ddc_pkg::ST_REL;
					end else begin
						state_q <= ddc_pkg::ST_REL;
					end
				end
				ddc_pkg::ST_FRAME: begin
					if (!gl_busy) begin
						state_q <= ret_q;
					end
				end
				ddc_pkg::ST_REL: begin
					// Release pressed buttons whose level went high
					if (mode_a_q == ddc_pkg::MODE_PRESSED && !a_low_q) begin
						mode_a_q <= ddc_pkg::MODE_RELEASED;
					end
					if (mode_b_q == ddc_pkg::MODE_PRESSED && !b_low_q) begin
						mode_b_q <= ddc_pkg::MODE_RELEASED;
					end
					state_q <= ddc_pkg::ST_IDLE;
				end
				default: begin
					state_q <= ddc_pkg::ST_IDLE;
				end
			endcase
		end
	end

endmodule
